// ===== rtl/ukfq_pkg.sv =====
// ukfq_pkg: shared types and codes for the unique-key queue
// payload structs, command and status codes, controller/datapath link structs
// no dependencies
package ukfq_pkg;

	// field widths fixed by the interface
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;
	localparam int OCC_W = 5;

	// default queue depth
	localparam int DEPTH_DEF = 16;

	// operation codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_DUP   = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd3;

	// request beat
	typedef struct packed {
		logic                    cmd;
		logic signed [KEY_W-1:0] entry_key;
		logic signed [VAL_W-1:0] entry_value;
	} req_t;

	// response beat
	typedef struct packed {
		logic        [STS_W-1:0] status;
		logic signed [KEY_W-1:0] out_key;
		logic signed [VAL_W-1:0] out_value;
		logic        [OCC_W-1:0] occupancy;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic rd_head;
		logic finish;
	} ukfq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_idle;
		logic out_free;
	} ukfq_sts_t;

endpackage

// ===== rtl/ukfq_ctrl.sv =====
// ukfq_ctrl: sequencing state machine of the unique-key queue
// drives datapath commands, takes one request beat at a time
// depends on ukfq_pkg
module ukfq_ctrl
	import ukfq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_cmd,
	output logic      req_stall,
	output ukfq_cmd_t cmd,
	input  ukfq_sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DEQ  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_cmd == CMD_DEQ) ? S_DEQ : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_idle) begin
					state_d = S_FIN;
				end
			end
			S_DEQ: begin
				cmd.rd_head = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/ukfq_dpath.sv =====
// ukfq_dpath: storage, pointers, key scan and response register of the queue
// key and value memories with one registered read port
// depends on ukfq_pkg
module ukfq_dpath
	import ukfq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  ukfq_cmd_t cmd,
	output ukfq_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_t      rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// storage
	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [VAL_W-1:0] val_mem [DEPTH];

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	// captured item
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// scan state
	logic [PTR_W-1:0] scan_ptr_q;
	logic [CNT_W-1:0] scan_left_q;
	logic             cmp_s1;
	logic             dup_q;

	// read port
	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;

	// response
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             push;
	logic             pop;
	logic [CNT_W-1:0] count_d;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
		if (i == PTR_W'(DEPTH - 1)) begin
			next_slot = '0;
		end else begin
			next_slot = i + 1'b1;
		end
	endfunction

	// read address: scan walks from head, dequeue reads head
	assign rd_en   = (cmd.scan && (scan_left_q != '0)) || cmd.rd_head;
	assign rd_addr = cmd.rd_head ? head_q : scan_ptr_q;

	assign sts.scan_idle = (scan_left_q == '0) && !cmp_s1;
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (push) begin
			key_mem[tail_q] <= key_q;
			val_mem[tail_q] <= val_q;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	// capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.cmd;
			key_q <= req.entry_key;
			val_q <= req.entry_value;
		end
	end

	// result of the operation
	always_comb begin
		push            = 1'b0;
		pop             = 1'b0;
		count_d         = count_q;
		rsp_d.status    = STS_OK;
		rsp_d.out_key   = '0;
		rsp_d.out_value = '0;
		if (op_q == CMD_ENQ) begin
			if (dup_q) begin
				rsp_d.status = STS_DUP;
			end else if (count_q == CNT_W'(DEPTH)) begin
				rsp_d.status = STS_FULL;
			end else begin
				push    = cmd.finish;
				count_d = count_q + 1'b1;
			end
		end else begin
			if (count_q == '0) begin
				rsp_d.status = STS_EMPTY;
			end else begin
				pop             = cmd.finish;
				count_d         = count_q - 1'b1;
				rsp_d.out_key   = rd_key_q;
				rsp_d.out_value = rd_val_q;
			end
		end
		rsp_d.occupancy = OCC_W'(count_d);
	end

	// pointers, occupancy and key scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_left_q <= '0;
			cmp_s1      <= 1'b0;
			dup_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				scan_ptr_q  <= head_q;
				scan_left_q <= count_q;
				cmp_s1      <= 1'b0;
				dup_q       <= 1'b0;
			end else if (cmd.scan) begin
				// issue one stored key a cycle, compare it the cycle after
				if (scan_left_q != '0) begin
					scan_ptr_q  <= next_slot(scan_ptr_q);
					scan_left_q <= scan_left_q - 1'b1;
					cmp_s1      <= 1'b1;
				end else begin
					cmp_s1 <= 1'b0;
				end
				if (cmp_s1 && (rd_key_q == key_q)) begin
					dup_q <= 1'b1;
				end
			end
			if (push) begin
				tail_q <= next_slot(tail_q);
			end
			if (pop) begin
				head_q <= next_slot(head_q);
			end
			if (cmd.finish) begin
				count_q <= count_d;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/unique_key_fifo_queue.sv =====
// unique_key_fifo_queue: top level of the first-in first-out queue with duplicate-key rejection
// joins the controller and the datapath
// depends on ukfq_pkg, ukfq_ctrl, ukfq_dpath
//
// A queue of up to DEPTH (key, value) entries. Each request beat either enqueues an
// entry or dequeues the oldest one, and gives exactly one response beat with a status
// (ok, duplicate key, empty, full), the dequeued key and value (zero otherwise) and the
// occupancy after the operation. An enqueue compares its key against every held entry,
// reading one stored key a cycle from a single memory read port; a duplicate wins over
// full. One request is worked on at a time; the next is taken once the previous
// response is loaded into the output register, even while that response is still
// stalled. Storage needs no clearing after reset.
module unique_key_fifo_queue
	import ukfq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ukfq_cmd_t cmd;
	ukfq_sts_t sts;

	// sequencing
	ukfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// storage and scan
	ukfq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for unique_key_fifo_queue, random and directed request beats
// predicts every response with a local copy of the queue and compares it field by field
// depends on ukfq_pkg and the unique_key_fifo_queue rtl
`timescale 1ns / 1ps

module testbench;
	import ukfq_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int KEY_POOL   = 20;
	localparam int LONG_HOLD  = 200;
	localparam int CYCLE_CAP  = 400000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	unique_key_fifo_queue #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// requests waiting to be offered and responses still owed
	req_t pending_reqs[$];
	rsp_t owed_rsps[$];

	// local copy of the queue contents
	logic signed [KEY_W-1:0] held_keys [DEPTH];
	logic signed [VAL_W-1:0] held_vals [DEPTH];
	int held_head  = 0;
	int held_tail  = 0;
	int held_count = 0;

	logic signed [KEY_W-1:0] key_pool [KEY_POOL];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_requests = 0;
	int  holds_done    = 0;
	int  hold_left     = 0;
	int  mismatch_count = 0;
	int  cycle_count   = 0;
	int  status_seen [4] = '{0, 0, 0, 0};
	int  beats_checked = 0;
	logic req_sent = 1'b0;

	// apply one request to the local queue and give the response it should produce
	function automatic rsp_t queue_step(input req_t r);
		rsp_t o;
		bit   dup;
		int   slot;
		o   = '0;
		dup = 1'b0;
		if (r.cmd == CMD_ENQ) begin
			slot = held_head;
			for (int n = 0; n < held_count; n++) begin
				if (held_keys[slot] == r.entry_key)
					dup = 1'b1;
				slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
			end
			if (dup) begin
				o.status = STS_DUP;
			end else if (held_count >= DEPTH) begin
				o.status = STS_FULL;
			end else begin
				held_keys[held_tail] = r.entry_key;
				held_vals[held_tail] = r.entry_value;
				held_tail  = (held_tail + 1 >= DEPTH) ? 0 : held_tail + 1;
				held_count = held_count + 1;
				o.status   = STS_OK;
			end
		end else begin
			if (held_count == 0) begin
				o.status = STS_EMPTY;
			end else begin
				o.out_key   = held_keys[held_head];
				o.out_value = held_vals[held_head];
				held_head   = (held_head + 1 >= DEPTH) ? 0 : held_head + 1;
				held_count  = held_count - 1;
				o.status    = STS_OK;
			end
		end
		o.occupancy = held_count[OCC_W-1:0];
		return o;
	endfunction

	// request driver, changes at the falling edge
	always @(negedge clk) begin : req_driver
		logic nv;
		req_t np;
		nv = req_valid;
		np = req;
		if (req_sent)
			nv = 1'b0;
		if (!nv && arst_n && pending_reqs.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			np = pending_reqs.pop_front();
			nv = 1'b1;
		end
		req_valid <= nv;
		req       <= np;
	end

	// response stall, with a long hold-off when one is asked for
	always @(negedge clk) begin : rsp_stall_driver
		logic ns;
		if (holds_done != hold_requests) begin
			hold_left  = LONG_HOLD;
			holds_done = holds_done + 1;
		end
		if (hold_left > 0) begin
			ns        = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			ns = ($urandom_range(99) < recv_idle_pct);
		end
		rsp_stall <= ns;
	end

	// monitor: predict accepted requests, check accepted responses
	always @(posedge clk) begin : beat_monitor
		rsp_t want;
		req_sent <= req_valid && !req_stall;
		if (arst_n && req_valid && req_stall === 1'b0)
			owed_rsps.push_back(queue_step(req));
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			beats_checked = beats_checked + 1;
			if (owed_rsps.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				$display("%0t: response beat with nothing owed, got %h", $time, rsp);
			end else begin
				want = owed_rsps.pop_front();
				status_seen[want.status] = status_seen[want.status] + 1;
				if (rsp.status !== want.status) begin
					mismatch_count = mismatch_count + 1;
					$display("%0t: status expected %0d got %0d", $time, want.status,
						rsp.status);
				end
				if (rsp.out_key !== want.out_key) begin
					mismatch_count = mismatch_count + 1;
					$display("%0t: out_key expected %h got %h", $time, want.out_key,
						rsp.out_key);
				end
				if (rsp.out_value !== want.out_value) begin
					mismatch_count = mismatch_count + 1;
					$display("%0t: out_value expected %h got %h", $time, want.out_value,
						rsp.out_value);
				end
				if (rsp.occupancy !== want.occupancy) begin
					mismatch_count = mismatch_count + 1;
					$display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
						rsp.occupancy);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("%0t: run limit reached, %0d responses owed", $time, owed_rsps.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic req_t make_req(input logic c, input logic [31:0] k,
			input logic [31:0] v);
		req_t r;
		r.cmd         = c;
		r.entry_key   = k;
		r.entry_value = v;
		return r;
	endfunction

	// random beats in runs with a drifting enqueue bias, keys mostly from a small pool
	task automatic queue_random_items(input int n);
		int   enq_pct;
		logic c;
		logic [31:0] k;
		enq_pct = 50;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				case ($urandom_range(3))
					0: enq_pct = 25;
					1: enq_pct = 50;
					2: enq_pct = 70;
					default: enq_pct = 90;
				endcase
			c = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
			k = ($urandom_range(99) < 70) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom;
			pending_reqs.push_back(make_req(c, k, $urandom));
		end
	endtask

	// sender pause until every owed response is back
	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_valid || owed_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty dequeue, key extremes, duplicates, fill, full, duplicate on full
		pending_reqs.push_back(make_req(CMD_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'h7FFF_FFFF, 32'h8000_0000));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'h0000_0000, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'hFFFF_FFFF, 32'h0000_0000));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'h8000_0000, 32'h1234_5678));
		for (int i = 0; i < DEPTH - 4; i++)
			pending_reqs.push_back(make_req(CMD_ENQ, 32'h100 + i, $urandom));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'h5555_AAAA, 32'hAAAA_5555));
		pending_reqs.push_back(make_req(CMD_ENQ, 32'h7FFF_FFFF, 32'h0));
		for (int i = 0; i < 3; i++)
			pending_reqs.push_back(make_req(CMD_DEQ, 32'h0, 32'h0));
		wait_drained();

		// random, receiver idles more than sender
		send_idle_pct = 38;
		recv_idle_pct = 56;
		queue_random_items(480);
		wait_drained();

		// random, sender idles more than receiver
		send_idle_pct = 56;
		recv_idle_pct = 38;
		queue_random_items(480);
		wait_drained();

		// random, no idling, with one long receiver hold-off to back the block up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_items(490);
		hold_requests = hold_requests + 1;
		wait_drained();

		repeat (3 * DEPTH) @(posedge clk);

		$display("checked %0d response beats: %0d ok, %0d duplicate, %0d empty, %0d full",
			beats_checked, status_seen[STS_OK], status_seen[STS_DUP],
			status_seen[STS_EMPTY], status_seen[STS_FULL]);
		$display("three idling mixes and one long receiver hold-off, %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0 && owed_rsps.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
